@@ hdl/fq_pkg.sv @@
// Shared types and constants for the float to int8/bf16 quantizer.
package fq_pkg;

  typedef enum logic [1:0] {
    MODE_INT8       = 2'd0,
    MODE_BF16_TRUNC = 2'd1,
    MODE_BF16_RNE   = 2'd2,
    MODE_U8_CLIP    = 2'd3
  } mode_e;

  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_SCALE = 1'b1;

  localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
  localparam logic [31:0] QNAN_F32    = 32'h7FC0_0000;

  typedef struct packed {
    logic [31:0] source_value;
    logic        last_element;
  } in_t;

  typedef struct packed {
    logic [15:0] converted_value;
    logic        last_out;
  } out_t;

  typedef struct packed {
    logic              zero;
    logic              inf;
    logic              nan;
    logic              sign;
    logic signed [9:0] exp;
    logic [23:0]       man;
  } op_t;

  typedef struct packed {
    logic              nan;
    logic              inf;
    logic              zero;
    logic              sign;
    logic signed [9:0] exp;
  } prod_ctl_t;

endpackage

@@ hdl/fq_unpack.sv @@
// First stage: operand unpack with subnormal normalization, and bf16/uint8 conversions.
module fq_unpack (
  input  logic [31:0]       src_i,
  input  logic [31:0]       scale_i,
  input  fq_pkg::mode_e     mode_i,
  output fq_pkg::prod_ctl_t ctl_o,
  output logic [23:0]       man_a_o,
  output logic [23:0]       man_b_o,
  output logic [15:0]       byp_o
);
  import fq_pkg::*;

  function automatic op_t unpack_op(input logic [31:0] x);
    op_t         o;
    logic [23:0] m;
    logic [4:0]  lz;
    begin
      o.sign = x[31];
      o.zero = (x[30:23] == 8'd0) && (x[22:0] == 23'd0);
      o.inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
      o.nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
      if (x[30:23] == 8'd0) begin
        m  = {1'b0, x[22:0]};
        lz = 5'd23;
        for (int i = 0; i < 24; i++) begin
          if (m[i]) lz = 5'(23 - i);
        end
        o.man = m << lz;
        o.exp = 10'sd1 - $signed({5'd0, lz});
      end else begin
        o.man = {1'b1, x[22:0]};
        o.exp = $signed({2'b00, x[30:23]});
      end
      return o;
    end
  endfunction

  function automatic logic [15:0] bf16_rne(input logic [31:0] x);
    logic [31:0] r;
    begin
      r = x + 32'h0000_7FFF + {31'd0, x[16]};
      if (x[30:23] == 8'd0) return {x[31], 15'd0};
      if (x[30:23] == 8'hFF) begin
        if (x[22:0] == 23'd0) return {x[31], 15'h7F80};
        return 16'h7F81;
      end
      if (r[30:23] == 8'hFF) return {x[31], 15'h7F80};
      return r[31:16];
    end
  endfunction

  op_t a, b;

  always_comb begin
    a = unpack_op(src_i);
    b = unpack_op(scale_i);
    ctl_o.nan  = a.nan || b.nan || (a.inf && b.zero) || (b.inf && a.zero);
    ctl_o.inf  = (a.inf || b.inf) && !ctl_o.nan;
    ctl_o.zero = (a.zero || b.zero) && !ctl_o.nan && !ctl_o.inf;
    ctl_o.sign = a.sign ^ b.sign;
    ctl_o.exp  = a.exp + b.exp - 10'sd127;
    man_a_o    = a.man;
    man_b_o    = b.man;
    case (mode_i)
      MODE_BF16_TRUNC: byp_o = src_i[31:16];
      MODE_BF16_RNE:   byp_o = bf16_rne(src_i);
      MODE_U8_CLIP:    byp_o = (src_i[7:0] >= 8'd127) ? 16'd127 : {8'd0, src_i[7:0]};
      default:         byp_o = 16'd0;
    endcase
  end

endmodule

@@ hdl/fq_round.sv @@
// Third stage: normalize and round the 48-bit product to a float32 bit pattern.
module fq_round (
  input  fq_pkg::prod_ctl_t ctl_i,
  input  logic [47:0]       prod_i,
  output logic [31:0]       pb_o
);
  import fq_pkg::*;

  logic [23:0]       sig;
  logic              guard, sticky, rnd;
  logic [24:0]       sig_r;
  logic signed [9:0] exp_f;

  always_comb begin
    if (prod_i[47]) begin
      sig    = prod_i[47:24];
      guard  = prod_i[23];
      sticky = |prod_i[22:0];
    end else begin
      sig    = prod_i[46:23];
      guard  = prod_i[22];
      sticky = |prod_i[21:0];
    end
    rnd   = guard && (sticky || sig[0]);
    sig_r = {1'b0, sig} + {24'd0, rnd};
    exp_f = ctl_i.exp + $signed({9'd0, prod_i[47]}) + $signed({9'd0, sig_r[24]});
    if (ctl_i.nan) begin
      pb_o = QNAN_F32;
    end else if (ctl_i.inf || exp_f >= 10'sd255) begin
      pb_o = {ctl_i.sign, 8'hFF, 23'd0};
    end else if (ctl_i.zero || exp_f <= 10'sd0) begin
      pb_o = {ctl_i.sign, 31'd0};
    end else begin
      pb_o = {ctl_i.sign, exp_f[7:0], sig_r[24] ? 23'd0 : sig_r[22:0]};
    end
  end

endmodule

@@ hdl/fq_int8.sv @@
// Fourth stage: round float32 to nearest-even integer, saturate to int8, select result.
module fq_int8 (
  input  logic [31:0]   pb_i,
  input  fq_pkg::mode_e mode_i,
  input  logic [15:0]   byp_i,
  output logic [15:0]   res_o
);
  import fq_pkg::*;

  logic [7:0]  e;
  logic [23:0] m;
  logic [4:0]  sh;
  logic [23:0] ip, rem, half;
  logic [7:0]  mag;
  logic [7:0]  q;

  always_comb begin
    e    = pb_i[30:23];
    m    = {1'b1, pb_i[22:0]};
    sh   = 5'(8'd150 - e);
    ip   = m >> sh;
    rem  = m & ((24'd1 << sh) - 24'd1);
    half = 24'd1 << (sh - 5'd1);
    mag  = ip[7:0];
    if (rem > half || (rem == half && ip[0])) mag = ip[7:0] + 8'd1;
    if (e == 8'hFF) begin
      q = (pb_i[22:0] != 23'd0) ? 8'h00 : (pb_i[31] ? 8'h80 : 8'h7F);
    end else if (e < 8'd126) begin
      q = 8'h00;
    end else if (e >= 8'd134) begin
      q = pb_i[31] ? 8'h80 : 8'h7F;
    end else if (pb_i[31]) begin
      q = ~mag + 8'd1;
    end else begin
      q = mag[7] ? 8'h7F : mag;
    end
    res_o = (mode_i == MODE_INT8) ? {8'd0, q} : byp_i;
  end

endmodule

@@ hdl/float_to_int8_bf16_quantizer_top.sv @@
// Top level of the float32 to int8/bf16 quantizer pipeline.
// Four-stage pipeline, one element per cycle while the output is not stalled:
// unpack and normalize, 24x24 mantissa multiply, float32 rounding,
// then integer rounding with int8 saturation and mode selection. Each stage holds
// its own valid bit and stalls only when the stage after it is full and stalled. Configuration
// writes are always taken; write them only while the pipeline is empty.
module float_to_int8_bf16_quantizer_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fq_pkg::in_t   in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fq_pkg::out_t  out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_index_i,
  input  logic [31:0]   cfg_data_i
);
  import fq_pkg::*;

  mode_e       mode_q;
  logic [31:0] scale_q;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  mode_e       s1_mode_q, s2_mode_q, s3_mode_q;
  logic        s1_last_q, s2_last_q, s3_last_q;
  logic [15:0] s1_byp_q, s2_byp_q, s3_byp_q;
  prod_ctl_t   s1_ctl_q, s2_ctl_q;
  logic [23:0] s1_ma_q, s1_mb_q;
  logic [47:0] s2_prod_q;
  logic [31:0] s3_pb_q;
  out_t        out_q;

  prod_ctl_t   ctl_d;
  logic [23:0] ma_d, mb_d;
  logic [15:0] byp_d;
  logic [31:0] pb_d;
  logic [15:0] res_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_INT8;
      scale_q <= SCALE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MODE:  mode_q  <= mode_e'(cfg_data_i[1:0]);
        CFG_SCALE: scale_q <= cfg_data_i;
        default:   scale_q <= scale_q;
      endcase
    end
  end

  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  fq_unpack u_unpack (
    .src_i   (in_data_i.source_value),
    .scale_i (scale_q),
    .mode_i  (mode_q),
    .ctl_o   (ctl_d),
    .man_a_o (ma_d),
    .man_b_o (mb_d),
    .byp_o   (byp_d)
  );

  fq_round u_round (
    .ctl_i  (s2_ctl_q),
    .prod_i (s2_prod_q),
    .pb_o   (pb_d)
  );

  fq_int8 u_int8 (
    .pb_i   (s3_pb_q),
    .mode_i (s3_mode_q),
    .byp_i  (s3_byp_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_mode_q <= mode_q;
      s1_last_q <= in_data_i.last_element;
      s1_byp_q  <= byp_d;
      s1_ctl_q  <= ctl_d;
      s1_ma_q   <= ma_d;
      s1_mb_q   <= mb_d;
    end
    if (rdy2 && v1_q) begin
      s2_mode_q <= s1_mode_q;
      s2_last_q <= s1_last_q;
      s2_byp_q  <= s1_byp_q;
      s2_ctl_q  <= s1_ctl_q;
      s2_prod_q <= s1_ma_q * s1_mb_q;
    end
    if (rdy3 && v2_q) begin
      s3_mode_q <= s2_mode_q;
      s3_last_q <= s2_last_q;
      s3_byp_q  <= s2_byp_q;
      s3_pb_q   <= pb_d;
    end
    if (rdy4 && v3_q) begin
      out_q.converted_value <= res_d;
      out_q.last_out        <= s3_last_q;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;

endmodule

@@ tb/float_to_int8_bf16_quantizer_top_tb.sv @@
// Self-checking testbench for the float32 to int8/bf16 quantizer top level.
module float_to_int8_bf16_quantizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fq_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned LONG_HOLD   = 60;
  localparam int unsigned DRAIN_WAIT  = 8;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam int          INT8_MAX    = 127;
  localparam int          INT8_MIN    = -128;
  localparam logic [14:0] BF16_INF    = 15'h7F80;
  localparam logic [15:0] BF16_NAN    = 16'h7F81;
  localparam logic [31:0] F32_SIGN    = 32'h8000_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_MODE;
  logic [31:0] cfg_data = '0;

  in_t  src_q[$];
  out_t expected_q[$];
  mode_e       cur_mode = MODE_INT8;
  logic [31:0] cur_scale = SCALE_RESET;

  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;
  bit          in_xfer = 1'b0;
  bit          out_xfer = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;

  float_to_int8_bf16_quantizer_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [15:0] round_clip_int8(logic sgn, int e_unb, logic [23:0] sig);
    int unsigned sh;
    int unsigned ip;
    int unsigned rem;
    int unsigned half;
    int          v;
    sh = 23 - e_unb;
    ip = sig >> sh;
    rem = sig & ((32'd1 << sh) - 1);
    half = 32'd1 << (sh - 1);
    if (rem > half || (rem == half && ip[0])) ip++;
    v = sgn ? -int'(ip) : int'(ip);
    if (v > INT8_MAX) v = INT8_MAX;
    if (v < INT8_MIN) v = INT8_MIN;
    return {8'h00, v[7:0]};
  endfunction

  function automatic logic [15:0] saturate_int8(logic sgn);
    int v;
    v = sgn ? INT8_MIN : INT8_MAX;
    return {8'h00, v[7:0]};
  endfunction

  function automatic logic [15:0] scaled_int8(logic [31:0] a, logic [31:0] b);
    logic        sgn;
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [63:0] prod;
    logic [63:0] rem;
    logic [63:0] half;
    logic [24:0] sig;
    int          msb;
    int          e_unb;
    int          sh;
    sgn    = a[31] ^ b[31];
    nan_a  = a[30:23] == 8'hFF && a[22:0] != 0;
    nan_b  = b[30:23] == 8'hFF && b[22:0] != 0;
    inf_a  = a[30:23] == 8'hFF && a[22:0] == 0;
    inf_b  = b[30:23] == 8'hFF && b[22:0] == 0;
    zero_a = a[30:0] == 0;
    zero_b = b[30:0] == 0;
    if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) return 16'h0000;
    if (inf_a || inf_b) return saturate_int8(sgn);
    if (zero_a || zero_b) return 16'h0000;
    prod = {40'd0, a[30:23] != 0, a[22:0]} * {40'd0, b[30:23] != 0, b[22:0]};
    msb = 0;
    for (int i = 0; i < 48; i++) if (prod[i]) msb = i;
    e_unb = msb - 46 + ((a[30:23] == 0) ? 1 : int'(a[30:23])) - 127
                     + ((b[30:23] == 0) ? 1 : int'(b[30:23])) - 127;
    if (e_unb < -1) return 16'h0000;
    if (e_unb >= 7) return saturate_int8(sgn);
    if (msb > 23) begin
      sh = msb - 23;
      sig = 25'(prod >> sh);
      rem = prod & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && sig[0])) sig++;
      if (sig[24]) begin
        sig = sig >> 1;
        e_unb++;
      end
    end else begin
      sig = 25'(prod << (23 - msb));
    end
    if (e_unb >= 7) return saturate_int8(sgn);
    return round_clip_int8(sgn, e_unb, sig[23:0]);
  endfunction

  function automatic logic [15:0] bf16_nearest_even(logic [31:0] x);
    logic [31:0] r;
    if (x[30:23] == 8'h00) return {x[31], 15'd0};
    if (x[30:23] == 8'hFF) return (x[22:0] == 0) ? {x[31], BF16_INF} : BF16_NAN;
    r = x + 32'h7FFF + x[16];
    if (r[30:23] == 8'hFF) return {x[31], BF16_INF};
    return r[31:16];
  endfunction

  function automatic out_t convert_element(in_t item);
    out_t res;
    res.last_out = item.last_element;
    case (cur_mode)
      MODE_INT8:       res.converted_value = scaled_int8(item.source_value, cur_scale);
      MODE_BF16_TRUNC: res.converted_value = item.source_value[31:16];
      MODE_BF16_RNE:   res.converted_value = bf16_nearest_even(item.source_value);
      default: begin
        res.converted_value = (item.source_value[7:0] >= 8'd127) ? 16'd127
                                                                 : {8'h00, item.source_value[7:0]};
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    errors++;
    $display("mismatch on result %0d: %s got %h, want %h", results_seen, field, got, want);
  endtask

  // driver: offer pending items with random gaps
  always @(negedge clk_i) begin
    logic nv;
    nv = in_valid;
    if (rst_ni) begin
      if (!in_valid || in_xfer) begin
        nv = 1'b0;
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (src_q.size() > 0) begin
          in_data <= src_q.pop_front();
          nv = 1'b1;
          tx_gap = quiet ? 0 : $urandom_range(0, 7);
        end
      end
    end
    in_valid <= nv;
  end

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk_i) begin
    logic nr;
    nr = 1'b1;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (out_xfer) rx_gap = quiet ? 0 : $urandom_range(0, 7);
    if (hold_left > 0) begin
      hold_left--;
      nr = 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      nr = 1'b0;
    end
    out_ready <= nr;
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk_i) begin
    out_t want;
    in_xfer <= in_valid && in_ready;
    out_xfer <= out_valid && out_ready;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        expected_q.push_back(convert_element(in_data));
        items_sent++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("unexpected result %h", out_data);
        end else begin
          want = expected_q.pop_front();
          if (out_data.converted_value !== want.converted_value)
            report_mismatch("converted_value", out_data.converted_value, want.converted_value);
          if (out_data.last_out !== want.last_out)
            report_mismatch("last_out", 16'(out_data.last_out), 16'(want.last_out));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (src_q.size() == 0 && expected_q.size() == 0 && !in_valid)) begin
        idle_cycles = 0;
      end else if (++idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("** float_to_int8_bf16_quantizer_top: FAILED **");
        $finish;
      end
    end
  end

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == CFG_MODE) cur_mode = mode_e'(val[1:0]);
    else cur_scale = val;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (src_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_source(mode_e m);
    logic [31:0] x;
    x = $urandom();
    case (m)
      MODE_INT8: begin
        if ($urandom_range(0, 1)) x[30:23] = 8'($urandom_range(112, 138));
        if ($urandom_range(0, 3) == 0) x[15:0] = 16'h0000;
      end
      MODE_BF16_RNE: begin
        case ($urandom_range(0, 5))
          0: x[15:0] = 16'h8000;
          1: x[30:23] = 8'h00;
          2: x[30:23] = 8'hFF;
          3: x[30:16] = 15'h7F7F;
          default: ;
        endcase
      end
      default: ;
    endcase
    return x;
  endfunction

  task automatic push_source(logic [31:0] x);
    in_t item;
    item.source_value = x;
    item.last_element = 1'($urandom_range(0, 1));
    src_q.push_back(item);
  endtask

  task automatic run_phase(mode_e m, logic [31:0] scl, bit calm, bit stall_out);
    write_reg(CFG_MODE, 32'(m));
    write_reg(CFG_SCALE, scl);
    quiet = calm;
    for (int i = 0; i < PHASE_ITEMS; i++) push_source(pick_source(m));
    if (stall_out) begin
      @(negedge clk_i);
      hold_req = ~hold_req;
    end
    drain();
  endtask

  initial begin
    logic [31:0] int8_cases[$];
    logic [31:0] bf16_cases[$];
    logic [31:0] clip_cases[$];
    int8_cases = '{32'h0000_0000, 32'h8000_0000, 32'h3F00_0000, 32'h3F00_0001,
      32'h3FC0_0000, 32'h4020_0000, 32'hC020_0000, 32'h42FE_0000, 32'h4300_0000, 32'hC300_0000,
      32'hC301_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h0000_0001, 32'hFFFF_FFFF};
    bf16_cases = '{32'h3F80_8000, 32'h3F81_8000, 32'h0012_3456, 32'h8012_3456,
      32'h7FC0_0001, 32'hFF80_0000, 32'h7F7F_FFFF, 32'h3F80_7FFF};
    clip_cases = '{32'hFFFF_FF7E, 32'h0000_007F, 32'h1234_5680, 32'h0000_00FF};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed corners for int8, bf16 rne and u8 clip modes at the reset scale
    foreach (int8_cases[i]) push_source(int8_cases[i]);
    drain();
    write_reg(CFG_MODE, 32'(MODE_BF16_RNE));
    foreach (bf16_cases[i]) push_source(bf16_cases[i]);
    drain();
    write_reg(CFG_MODE, 32'(MODE_U8_CLIP));
    foreach (clip_cases[i]) push_source(clip_cases[i]);
    drain();

    run_phase(MODE_INT8,       SCALE_RESET,  1'b0, 1'b0);
    run_phase(MODE_INT8,       32'h3C00_0000, 1'b1, 1'b0);
    run_phase(MODE_INT8,       32'h42FE_0000, 1'b0, 1'b1);
    run_phase(MODE_INT8,       {1'($urandom_range(0, 1)), 8'($urandom_range(120, 134)),
                                23'($urandom())}, 1'b0, 1'b0);
    run_phase(MODE_INT8,       32'h0000_0000, 1'b0, 1'b0);
    run_phase(MODE_INT8,       32'hFFFF_FFFF, 1'b0, 1'b0);
    run_phase(MODE_BF16_TRUNC, 32'h0000_0001, 1'b1, 1'b0);
    run_phase(MODE_BF16_RNE,   F32_SIGN,      1'b0, 1'b1);
    run_phase(MODE_U8_CLIP,    SCALE_RESET,   1'b0, 1'b0);
    run_phase(MODE_INT8,       32'h7F80_0000, 1'b0, 1'b0);

    if (expected_q.size() > 0) begin
      errors++;
      $display("%0d expected results never arrived", expected_q.size());
    end
    $display("covered all four modes with corner and random elements over %0d scale settings",
             9);
    $display("%0d elements sent, %0d results checked, %0d errors",
             items_sent, results_seen, errors);
    if (errors == 0) begin
      $display("** float_to_int8_bf16_quantizer_top: PASSED **");
    end else begin
      $display("** float_to_int8_bf16_quantizer_top: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/fq_pkg.sv
hdl/fq_unpack.sv
hdl/fq_round.sv
hdl/fq_int8.sv
hdl/float_to_int8_bf16_quantizer_top.sv
tb/float_to_int8_bf16_quantizer_top_tb.sv
